// ===== sv/dtmr_pkg.sv =====
package dtmr_pkg;

	// item kinds
	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_WRITE = 2'd2;

	// register words of one counter
	localparam logic [2:0] OFF_LOAD   = 3'd0;
	localparam logic [2:0] OFF_VALUE  = 3'd1;
	localparam logic [2:0] OFF_CTRL   = 3'd2;
	localparam logic [2:0] OFF_INTCLR = 3'd3;
	localparam logic [2:0] OFF_RAW    = 3'd4;
	localparam logic [2:0] OFF_MASKED = 3'd5;
	localparam logic [2:0] OFF_BGLOAD = 3'd6;

	// control word bit positions
	localparam int CTRL_ENABLE   = 7;
	localparam int CTRL_PERIODIC = 6;
	localparam int CTRL_INTEN    = 5;
	localparam int CTRL_LEN32    = 1;
	localparam int CTRL_ONESHOT  = 0;

	localparam logic [7:0]  CTRL_STORED = 8'hEF;
	localparam logic [7:0]  CTRL_RESET  = 8'h20;
	localparam logic [31:0] MASK_16     = 32'h0000_FFFF;
	localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

	localparam int IRQ_W   = 4;
	localparam int TDATA_W = 40;

	typedef struct packed {
		logic [1:0]  mode;
		logic [2:0]  offset;
		logic [31:0] wdata;
	} dtmr_req_t;

endpackage

// ===== sv/dual_down_counter_timer_core.sv =====
// A request that is accepted sits in the input register; its result, with the new
// counter state, is loaded into the result register when the input register advances.
// Throughput: one request per cycle; a stalled result stalls input only once
// the input register is also full.
// Reset (arst_n low): counts all ones, load words zero, control 0x20, no
// interrupts pending, both pipeline stages empty.
module dual_down_counter_timer_core
	import dtmr_pkg::*;
#(
	parameter int NUM_TIMERS         = 2,
	parameter int COUNTERS_PER_TIMER = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// [1:0] timer_select, [2] counter_select, [5:3] reg_offset, [37:6] write_data
	input  logic [TDATA_W-1:0] s_axis_tdata,
	// [1:0] mode
	input  logic [1:0]         s_axis_tuser,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// [31:0] read_data, [35:32] irq_lines
	output logic [TDATA_W-1:0] m_axis_tdata
);

	localparam int SLOTS = NUM_TIMERS * COUNTERS_PER_TIMER;

	logic        valid_s1;
	dtmr_req_t   req_s1;
	logic [1:0]  tsel_s1;
	logic        csel_s1;

	logic             valid_s2;
	logic [31:0]      rdata_s2;
	logic [IRQ_W-1:0] irq_s2;

	logic             adv;
	logic [31:0]      slot_rdata [SLOTS];
	logic [SLOTS-1:0] slot_irq;
	logic [31:0]      rdata_all;
	logic [IRQ_W-1:0] irq_all;

	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1.mode   <= s_axis_tuser;
			req_s1.offset <= s_axis_tdata[5:3];
			req_s1.wdata  <= s_axis_tdata[37:6];
			tsel_s1       <= s_axis_tdata[1:0];
			csel_s1       <= s_axis_tdata[2];
		end
	end

	for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_timer
		for (genvar k = 0; k < COUNTERS_PER_TIMER; k++) begin : g_counter
			dtmr_slot u_slot (
				.clk      (clk),
				.arst_n   (arst_n),
				.strobe   (adv),
				.sel      ((tsel_s1 == 2'(t)) && (csel_s1 == 1'(k))),
				.req      (req_s1),
				.rdata    (slot_rdata[t*COUNTERS_PER_TIMER+k]),
				.irq_next (slot_irq[t*COUNTERS_PER_TIMER+k])
			);
		end
	end

	// only the selected slot drives a nonzero read word
	always_comb begin
		rdata_all = '0;
		for (int i = 0; i < SLOTS; i++) begin
			rdata_all = rdata_all | slot_rdata[i];
		end
	end

	// drop counters whose interrupt bit falls beyond the vector
	always_comb begin
		irq_all = '0;
		for (int t = 0; t < NUM_TIMERS; t++) begin
			for (int k = 0; k < COUNTERS_PER_TIMER; k++) begin
				if (t * 2 + k < IRQ_W) begin
					irq_all[t*2+k] = slot_irq[t*COUNTERS_PER_TIMER+k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rdata_s2 <= rdata_all;
			irq_s2   <= irq_all;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(TDATA_W - 32 - IRQ_W){1'b0}}, irq_s2, rdata_s2};

`ifndef SYNTHESIS
	a_rdata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (req_s1.mode != MODE_READ) |=> m_axis_tdata[31:0] == '0)
		else $error("nonzero read word for a tick or write");

	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_axis_tvalid)
		else $error("result register not loaded after advance");

	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |-> !s_axis_tready)
		else $error("input taken while input register is stalled");

	a_s1_keep: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(req_s1))
		else $error("stalled request lost");
`endif

endmodule

// ===== sv/dtmr_slot.sv =====
module dtmr_slot
	import dtmr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        strobe,
	input  logic        sel,
	input  dtmr_req_t   req,
	output logic [31:0] rdata,
	output logic        irq_next
);

	logic [31:0] reload_q, count_q;
	logic [7:0]  ctrl_q;
	logic        raw_q;

	logic [31:0] reload_d, count_d, mask, cur, nxt;
	logic [7:0]  ctrl_d;
	logic        raw_d;

	always_comb begin
		mask     = ctrl_q[CTRL_LEN32] ? ALL_ONES : MASK_16;
		cur      = count_q & mask;
		nxt      = '0;
		reload_d = reload_q;
		count_d  = count_q;
		ctrl_d   = ctrl_q;
		raw_d    = raw_q;
		rdata    = '0;
		unique case (req.mode)
			MODE_TICK: begin
				if (ctrl_q[CTRL_ENABLE]) begin
					if (cur == '0) begin
						if (ctrl_q[CTRL_ONESHOT]) begin
							// one-shot: stay at zero, no new interrupt
							count_d = '0;
						end else begin
							nxt     = ctrl_q[CTRL_PERIODIC] ? (reload_q & mask) : mask;
							count_d = nxt;
							if (nxt == '0) raw_d = 1'b1;
						end
					end else begin
						nxt     = (cur - 32'd1) & mask;
						count_d = nxt;
						if (nxt == '0) raw_d = 1'b1;
					end
				end
			end
			MODE_READ: begin
				if (sel) begin
					unique case (req.offset)
						OFF_LOAD:   rdata = reload_q;
						OFF_VALUE:  rdata = count_q;
						OFF_CTRL:   rdata = {24'd0, ctrl_q};
						OFF_RAW:    rdata = {31'd0, raw_q};
						OFF_MASKED: rdata = {31'd0, raw_q & ctrl_q[CTRL_INTEN]};
						OFF_BGLOAD: rdata = reload_q;
						default:    rdata = '0;
					endcase
				end
			end
			MODE_WRITE: begin
				if (sel) begin
					unique case (req.offset)
						OFF_LOAD: begin
							reload_d = req.wdata;
							count_d  = req.wdata & mask;
						end
						OFF_CTRL:   ctrl_d   = req.wdata[7:0] & CTRL_STORED;
						OFF_INTCLR: raw_d    = 1'b0;
						OFF_BGLOAD: reload_d = req.wdata;
						default: ;
					endcase
				end
			end
			default: ;
		endcase
		irq_next = raw_d & ctrl_d[CTRL_INTEN];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= '0;
			count_q  <= ALL_ONES;
			ctrl_q   <= CTRL_RESET;
			raw_q    <= 1'b0;
		end else if (strobe) begin
			reload_q <= reload_d;
			count_q  <= count_d;
			ctrl_q   <= ctrl_d;
			raw_q    <= raw_d;
		end
	end

endmodule

// ===== tb/testbench.sv =====
import dtmr_pkg::*;

typedef struct packed {
	logic [31:0]      read_data;
	logic [IRQ_W-1:0] irq_lines;
} timer_result_t;

// Tracks the counter bank and holds the results it should produce, oldest first.
class timer_bank_scoreboard #(int TIMERS = 2, int CPT = 2);
	localparam int SLOTS = TIMERS * CPT;

	logic [31:0] load_word[SLOTS];
	logic [31:0] count_word[SLOTS];
	logic [7:0]  ctrl_word[SLOTS];
	bit          raw_irq[SLOTS];
	timer_result_t expected_results[$];
	int errors;

	function new();
		for (int s = 0; s < SLOTS; s++) begin
			load_word[s]  = '0;
			count_word[s] = ALL_ONES;
			ctrl_word[s]  = CTRL_RESET;
			raw_irq[s]    = 1'b0;
		end
		errors = 0;
	endfunction

	function logic [31:0] width_mask(int s);
		return ctrl_word[s][CTRL_LEN32] ? ALL_ONES : MASK_16;
	endfunction

	function void count_down(int s);
		logic [31:0] m;
		logic [31:0] c;
		if (!ctrl_word[s][CTRL_ENABLE])
			return;
		m = width_mask(s);
		c = count_word[s] & m;
		if (c == 0) begin
			// one-shot parks at zero without raising again
			if (ctrl_word[s][CTRL_ONESHOT]) begin
				count_word[s] = '0;
				return;
			end
			c = ctrl_word[s][CTRL_PERIODIC] ? (load_word[s] & m) : m;
			if (c == 0)
				raw_irq[s] = 1'b1;
		end else begin
			c = (c - 1) & m;
			if (c == 0)
				raw_irq[s] = 1'b1;
		end
		count_word[s] = c;
	endfunction

	function logic [IRQ_W-1:0] irq_vector();
		logic [IRQ_W-1:0] v;
		int b;
		v = '0;
		for (int t = 0; t < TIMERS; t++)
			for (int k = 0; k < CPT; k++) begin
				b = t * 2 + k;
				if (b < IRQ_W && raw_irq[t*CPT+k] && ctrl_word[t*CPT+k][CTRL_INTEN])
					v[b] = 1'b1;
			end
		return v;
	endfunction

	function void note_request(logic [1:0] mode, logic [1:0] tsel, logic csel,
			logic [2:0] off, logic [31:0] wdata);
		timer_result_t want;
		bit valid;
		int s;
		want.read_data = '0;
		valid = (tsel < TIMERS) && (csel < CPT);
		s = valid ? tsel * CPT + csel : 0;
		if (mode == MODE_TICK) begin
			for (int i = 0; i < SLOTS; i++)
				count_down(i);
		end else if (mode == MODE_READ && valid) begin
			case (off)
				OFF_LOAD, OFF_BGLOAD: want.read_data = load_word[s];
				OFF_VALUE:  want.read_data = count_word[s];
				OFF_CTRL:   want.read_data = {24'd0, ctrl_word[s]};
				OFF_RAW:    want.read_data = {31'd0, raw_irq[s]};
				OFF_MASKED: want.read_data = {31'd0, raw_irq[s] & ctrl_word[s][CTRL_INTEN]};
				default:    want.read_data = '0;
			endcase
		end else if (mode == MODE_WRITE && valid) begin
			case (off)
				OFF_LOAD: begin
					load_word[s]  = wdata;
					count_word[s] = wdata & width_mask(s);
				end
				OFF_CTRL:   ctrl_word[s] = wdata[7:0] & CTRL_STORED;
				OFF_INTCLR: raw_irq[s] = 1'b0;
				OFF_BGLOAD: load_word[s] = wdata;
				default: ;
			endcase
		end
		want.irq_lines = irq_vector();
		expected_results.push_back(want);
	endfunction

	function void flag_error(string msg);
		errors++;
		if (errors <= 10)
			$display("mismatch: %s", msg);
	endfunction

	function void check_result(logic [TDATA_W-1:0] beat);
		timer_result_t want;
		if (expected_results.size() == 0) begin
			flag_error($sformatf("result %h with nothing outstanding", beat));
			return;
		end
		want = expected_results.pop_front();
		if (beat[31:0] !== want.read_data)
			flag_error($sformatf("read_data expected %h got %h", want.read_data, beat[31:0]));
		if (beat[32 +: IRQ_W] !== want.irq_lines)
			flag_error($sformatf("irq_lines expected %h got %h", want.irq_lines,
				beat[32 +: IRQ_W]));
	endfunction

	function int pending();
		return expected_results.size();
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_TIMERS         = 2;
	localparam int COUNTERS_PER_TIMER = 2;
	localparam int STALL_LIMIT        = 5000;
	localparam int RANDOM_REQUESTS    = 2100;
	localparam logic [1:0] MODE_UNDEF = 2'd3;
	localparam logic [2:0] OFF_UNUSED = 3'd7;

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata;
	logic [1:0]         s_axis_tuser;
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [TDATA_W-1:0] m_axis_tdata;

	timer_bank_scoreboard #(NUM_TIMERS, COUNTERS_PER_TIMER) bank;
	bit tx_quiet;
	bit rx_quiet;
	int idle_cycles;

	dual_down_counter_timer_core #(
		.NUM_TIMERS(NUM_TIMERS),
		.COUNTERS_PER_TIMER(COUNTERS_PER_TIMER)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// mostly short gaps, a few long ones
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function logic [31:0] pick_data();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return $urandom;
		if (r < 35)
			return {16'($urandom_range(0, 65535)), 16'd0} | 32'($urandom_range(0, 4));
		return $urandom_range(0, 6);
	endfunction

	function logic [1:0] pick_timer();
		if ($urandom_range(0, 99) < 85)
			return 2'($urandom_range(0, NUM_TIMERS - 1));
		return 2'($urandom_range(0, 3));
	endfunction

	task send_request(input logic [1:0] mode, input logic [1:0] tsel, input logic csel,
			input logic [2:0] off, input logic [31:0] wdata);
		int gap;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {2'b00, wdata, off, csel, tsel};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		bank.note_request(mode, tsel, csel, off, wdata);
		gap = tx_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// drop the request line, then hold until every result is back
	task wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (bank.pending() != 0)
			@(posedge clk);
	endtask

	task send_random_request();
		int r;
		logic [7:0] ctl;
		r = $urandom_range(0, 99);
		if (r < 45)
			send_request(MODE_TICK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				3'($urandom_range(0, 7)), $urandom);
		else if (r < 60)
			send_request(MODE_READ, pick_timer(), 1'($urandom_range(0, 1)),
				3'($urandom_range(0, 7)), $urandom);
		else if (r < 70)
			send_request(MODE_WRITE, pick_timer(), 1'($urandom_range(0, 1)), OFF_LOAD,
				pick_data());
		else if (r < 78) begin
			ctl = 8'($urandom);
			ctl[CTRL_ENABLE] = ($urandom_range(0, 99) < 70);
			send_request(MODE_WRITE, pick_timer(), 1'($urandom_range(0, 1)), OFF_CTRL,
				{24'($urandom), ctl});
		end else if (r < 85)
			send_request(MODE_WRITE, pick_timer(), 1'($urandom_range(0, 1)), OFF_INTCLR,
				$urandom);
		else if (r < 90)
			send_request(MODE_WRITE, pick_timer(), 1'($urandom_range(0, 1)), OFF_BGLOAD,
				pick_data());
		else if (r < 97)
			send_request(MODE_WRITE, pick_timer(), 1'($urandom_range(0, 1)),
				3'($urandom_range(0, 7)), $urandom);
		else
			send_request(MODE_UNDEF, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				3'($urandom_range(0, 7)), $urandom);
	endtask

	// result side: random stalls, with stretches of none
	initial begin
		int stall;
		stall = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 299) == 0)
				rx_quiet = ~rx_quiet;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
				if (!rx_quiet && $urandom_range(0, 99) < 30)
					stall = pick_gap();
			end
		end
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			bank.check_result(m_axis_tdata);

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("testbench: errors");
				$finish;
			end
		end
	end

	initial begin
		bank = new();
		idle_cycles = 0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = MODE_TICK;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values
		send_request(MODE_READ, 2'd0, 1'b0, OFF_VALUE, 32'd0);
		send_request(MODE_READ, 2'd1, 1'b1, OFF_CTRL, 32'd0);
		send_request(MODE_READ, 2'd1, 1'b0, OFF_MASKED, 32'd0);
		// 16-bit load keeps only the low half in the count
		send_request(MODE_WRITE, 2'd0, 1'b0, OFF_LOAD, 32'hABCD_0003);
		send_request(MODE_READ, 2'd0, 1'b0, OFF_VALUE, 32'd0);
		// reserved bit 4 drops; periodic 16-bit with bit 2 set
		send_request(MODE_WRITE, 2'd0, 1'b0, OFF_CTRL, 32'hFFFF_FFF4);
		repeat (4) send_request(MODE_TICK, 2'd3, 1'b1, OFF_UNUSED, ALL_ONES);
		send_request(MODE_READ, 2'd0, 1'b0, OFF_RAW, 32'd0);
		send_request(MODE_READ, 2'd0, 1'b0, OFF_MASKED, 32'd0);
		send_request(MODE_WRITE, 2'd0, 1'b0, OFF_INTCLR, ALL_ONES);
		// read-only and unused words ignore writes
		send_request(MODE_WRITE, 2'd0, 1'b0, OFF_VALUE, 32'h1234_5678);
		send_request(MODE_WRITE, 2'd0, 1'b0, OFF_RAW, ALL_ONES);
		send_request(MODE_WRITE, 2'd0, 1'b0, OFF_UNUSED, ALL_ONES);
		// 32-bit one-shot stays at zero
		send_request(MODE_WRITE, 2'd1, 1'b1, OFF_LOAD, 32'd1);
		send_request(MODE_WRITE, 2'd1, 1'b1, OFF_CTRL, ALL_ONES);
		send_request(MODE_TICK, 2'd0, 1'b0, OFF_LOAD, 32'd0);
		send_request(MODE_TICK, 2'd0, 1'b0, OFF_LOAD, 32'd0);
		send_request(MODE_WRITE, 2'd1, 1'b1, OFF_BGLOAD, 32'h8000_0000);
		send_request(MODE_READ, 2'd1, 1'b1, OFF_BGLOAD, 32'd0);
		// out-of-range timer selects, and an undefined mode
		send_request(MODE_WRITE, 2'd3, 1'b1, OFF_LOAD, 32'h55);
		send_request(MODE_READ, 2'd2, 1'b0, OFF_LOAD, 32'd0);
		send_request(MODE_UNDEF, 2'd1, 1'b1, OFF_UNUSED, ALL_ONES);

		// hold off until the bank has answered everything
		wait_drained();

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 100 == 0)
				tx_quiet = ($urandom_range(0, 3) == 0);
			if (n % 700 == 350)
				wait_drained();
			send_random_request();
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);
		if (bank.errors == 0 && bank.pending() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule

// ===== sim.f =====
sv/dtmr_pkg.sv
sv/dtmr_slot.sv
sv/dual_down_counter_timer_core.sv
tb/testbench.sv
